@@ rtl/color_pool_dedupe_nearest_unit_assert.svh @@
// Assertion macros for the color pool unit.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef COLOR_POOL_DEDUPE_NEAREST_UNIT_ASSERT_SVH
`define COLOR_POOL_DEDUPE_NEAREST_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CPDN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("color pool unit: same-cycle check failed");
`define CPDN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("color pool unit: next-cycle check failed");
`else
`define CPDN_ASSERT_IMP(lbl, ante, cons)
`define CPDN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/cpdn_pkg.sv @@
package cpdn_pkg;

  localparam int COLOR_W = 15;
  localparam int CHAN_W  = 5;
  localparam int IDX_W   = 8;
  localparam int DIST_W  = 12;

  typedef logic [1:0] req_t;
  localparam req_t REQ_REGISTER = 2'd0;
  localparam req_t REQ_RANGE    = 2'd1;
  localparam req_t REQ_ALL      = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_INVALID   = 2'd1;
  localparam status_t STAT_FULL      = 2'd2;
  localparam status_t STAT_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_RESP = 2'd2
  } state_t;

endpackage

@@ rtl/color_pool_dedupe_nearest_unit.sv @@
// Color pool with exact-match registration and nearest-color lookup. The stored RGB555
// colors live in one synchronous memory with a single read per cycle, and an entry count
// in flip-flops tells which entries hold data, so no clearing pass is needed after reset.
// Each request is handled on its own: a request scans N entries (all stored entries
// for a register or nearest-over-all request, range_count entries for a ranged one)
// with one memory read per cycle; the decision follows once the last read is back.
// The result then waits in the response state until the output register is free.
// Requests answered without a scan (bad range, empty search, zero capacity, unused
// type) go from the idle state straight to the response state. The unit is ready for
// the next input at the same edge that raises out_valid. A finished result sits in an
// output register, so the next input transfer is taken while that result still waits.
// The capacity register may be written at any time the unit is idle; cfg_ready is always
// high.
`include "color_pool_dedupe_nearest_unit_assert.svh"

module color_pool_dedupe_nearest_unit
  import cpdn_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [COLOR_W-1:0] in_color,
  input  logic [IDX_W-1:0]   in_range_first,
  input  logic [IDX_W-1:0]   in_range_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_index,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_W = (IDX_W+1)'(TABLE_DEPTH);

  // Color memory: written once per appended color, read once per scan cycle.
  logic [COLOR_W-1:0] mem [TABLE_DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_raddr;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] rd_data_r;

  // Control state.
  state_t           state_r, state_nxt;
  logic [7:0]       cap_r, cap_nxt;
  logic [IDX_W-1:0] entry_count_r, entry_count_nxt;
  logic [IDX_W-1:0] remain_r, remain_nxt;
  logic             pv_r, pv_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request context and running search results.
  req_t               req_r, req_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   tag_r, tag_nxt;
  logic               found_r, found_nxt;
  logic [DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]   res_index_r, res_index_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   out_index_r, out_index_nxt;
  status_t            out_status_r, out_status_nxt;

  logic [DIST_W-1:0] cur_dist;
  logic              table_full;
  logic [IDX_W:0]    range_end;

  cpdn_dist u_dist (
    .color_a (color_r),
    .color_b (rd_data_r),
    .sq_dist (cur_dist)
  );

  // The effective capacity is the smaller of the register and the table depth.
  assign table_full = (entry_count_r >= cap_r) || ({1'b0, entry_count_r} >= DEPTH_W);
  assign range_end  = {1'b0, in_range_first} + {1'b0, in_range_count};

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;
  assign mem_waddr  = entry_count_r[AW-1:0];

  always_comb begin
    state_nxt       = state_r;
    cap_nxt         = (cfg_valid && cfg_ready) ? cfg_data : cap_r;
    entry_count_nxt = entry_count_r;
    remain_nxt      = remain_r;
    pv_nxt          = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    req_nxt         = req_r;
    color_nxt       = color_r;
    addr_nxt        = addr_r;
    tag_nxt         = tag_r;
    found_nxt       = found_r;
    best_dist_nxt   = best_dist_r;
    best_idx_nxt    = best_idx_r;
    res_index_nxt   = res_index_r;
    res_status_nxt  = res_status_r;
    out_index_nxt   = out_index_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_raddr       = addr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_req_type;
          color_nxt     = in_color;
          found_nxt     = 1'b0;
          best_dist_nxt = '1;
          best_idx_nxt  = '0;
          res_index_nxt = '0;
          addr_nxt      = '0;
          remain_nxt    = entry_count_r;
          case (in_req_type)
            REQ_REGISTER: begin
              if (cap_r == 8'd0) begin
                res_status_nxt = STAT_INVALID;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_RANGE: begin
              if (range_end > {1'b0, entry_count_r}) begin
                res_status_nxt = STAT_INVALID;
                state_nxt      = S_RESP;
              end else if (in_range_count == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
                state_nxt      = S_RESP;
              end else begin
                addr_nxt   = in_range_first;
                remain_nxt = in_range_count;
                state_nxt  = S_SCAN;
              end
            end
            REQ_ALL: begin
              if (entry_count_r == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = STAT_INVALID;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; its data returns with the index tag in the next cycle.
        if (remain_r != '0) begin
          pv_nxt     = 1'b1;
          tag_nxt    = addr_r;
          addr_nxt   = addr_r + 1'b1;
          remain_nxt = remain_r - 1'b1;
        end
        if (pv_r) begin
          if (req_r == REQ_REGISTER) begin
            if (!found_r && (rd_data_r == color_r)) begin
              found_nxt    = 1'b1;
              best_idx_nxt = tag_r;
            end
          end else if (cur_dist < best_dist_r) begin
            best_dist_nxt = cur_dist;
            best_idx_nxt  = tag_r;
          end
        end
        if (remain_r == '0 && !pv_r) begin
          state_nxt = S_RESP;
          if (req_r == REQ_REGISTER) begin
            if (found_r) begin
              res_status_nxt = STAT_OK;
              res_index_nxt  = best_idx_r;
            end else if (table_full) begin
              res_status_nxt = STAT_FULL;
              res_index_nxt  = '0;
            end else begin
              mem_we          = 1'b1;
              res_status_nxt  = STAT_OK;
              res_index_nxt   = entry_count_r;
              entry_count_nxt = entry_count_r + 1'b1;
            end
          end else begin
            res_status_nxt = STAT_OK;
            res_index_nxt  = best_idx_r;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = res_index_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= color_r;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cap_r         <= 8'd255;
      entry_count_r <= '0;
      remain_r      <= '0;
      pv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cap_r         <= cap_nxt;
      entry_count_r <= entry_count_nxt;
      remain_r      <= remain_nxt;
      pv_r          <= pv_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    color_r      <= color_nxt;
    addr_r       <= addr_nxt;
    tag_r        <= tag_nxt;
    found_r      <= found_nxt;
    best_dist_r  <= best_dist_nxt;
    best_idx_r   <= best_idx_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  // The table never holds more entries than it has rows.
  `CPDN_ASSERT_IMP(a_count_in_depth, 1'b1, {1'b0, entry_count_r} <= DEPTH_W)
  // A color is appended only while the table has room under the capacity.
  `CPDN_ASSERT_IMP(a_write_has_room, mem_we, entry_count_r < cap_r)
  // The entry count only ever grows by one.
  `CPDN_ASSERT_NXT(a_count_steps, 1'b1,
    entry_count_r == $past(entry_count_r) || entry_count_r == $past(entry_count_r) + 8'd1)
  // Memory read data is consumed only during a scan.
  `CPDN_ASSERT_IMP(a_read_in_scan, pv_r, state_r == S_SCAN)
  // A result that is not ok carries index zero.
  `CPDN_ASSERT_IMP(a_fail_index_zero, out_valid_r && out_status_r != STAT_OK,
    out_index_r == '0)

endmodule

@@ rtl/cpdn_dist.sv @@
// Squared RGB555 distance: sum of the squared differences of the three channels.
module cpdn_dist
  import cpdn_pkg::*;
(
  input  logic [COLOR_W-1:0] color_a,
  input  logic [COLOR_W-1:0] color_b,
  output logic [DIST_W-1:0]  sq_dist
);

  logic [CHAN_W-1:0]   diff [3];
  logic [2*CHAN_W-1:0] sq   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (color_a[c*CHAN_W +: CHAN_W] > color_b[c*CHAN_W +: CHAN_W]) begin
        diff[c] = color_a[c*CHAN_W +: CHAN_W] - color_b[c*CHAN_W +: CHAN_W];
      end else begin
        diff[c] = color_b[c*CHAN_W +: CHAN_W] - color_a[c*CHAN_W +: CHAN_W];
      end
      sq[c] = {{CHAN_W{1'b0}}, diff[c]} * {{CHAN_W{1'b0}}, diff[c]};
    end
    sq_dist = DIST_W'({2'b00, sq[0]}) + DIST_W'({2'b00, sq[1]}) + DIST_W'({2'b00, sq[2]});
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the color pool unit. Requests are queued by the stimulus process and
// presented by a bursty driver. At each input transfer a software copy of the color
// table answers the request, and the answer is queued. A monitor behind a stalling
// ready compares every result transfer with the oldest queued answer.
module tb_top;
  import cpdn_pkg::*;

  localparam int TABLE_DEPTH = 256;

  // The package names only three request kinds. The fourth code must be rejected.
  localparam req_t REQ_UNUSED = 2'd3;

  // The largest capacity that the 8-bit register can hold.
  localparam logic [7:0] CAP_MAX = 8'd255;

  typedef struct packed {
    req_t               kind;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   count;
  } color_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    status_t          status;
  } pool_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = REQ_REGISTER;
  logic [COLOR_W-1:0] in_color = '0;
  logic [IDX_W-1:0]   in_range_first = '0;
  logic [IDX_W-1:0]   in_range_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IDX_W-1:0]   out_index;
  logic [1:0]         out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;

  // Software copy of the pool. It starts in the reset state of the unit and is only
  // updated at input transfers and capacity writes.
  logic [COLOR_W-1:0] pool_colors [TABLE_DEPTH];
  logic [IDX_W-1:0]   pool_count = '0;
  logic [7:0]         pool_capacity = CAP_MAX;

  color_req_t   color_requests [$];
  pool_answer_t predicted_answers [$];
  int           error_count = 0;

  always #5 clk = ~clk;

  color_pool_dedupe_nearest_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_color      (in_color),
    .in_range_first(in_range_first),
    .in_range_count(in_range_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_index     (out_index),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Squared distance summed over the red, green and blue channels. The largest value,
  // three times 31 squared, fits in DIST_W bits.
  function automatic logic [DIST_W-1:0] rgb_distance(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
    int acc;
    int diff;
    acc = 0;
    for (int ch = 0; ch < 3; ch++) begin
      diff = int'(a[ch*CHAN_W +: CHAN_W]) - int'(b[ch*CHAN_W +: CHAN_W]);
      acc += diff * diff;
    end
    return acc[DIST_W-1:0];
  endfunction

  // Nearest stored color among count entries starting at first. The strict compare
  // keeps the lowest index on a tie.
  function automatic pool_answer_t nearest_color(input logic [COLOR_W-1:0] color,
                                                 input int first, input int count);
    pool_answer_t ans;
    int best;
    int cand_dist;
    ans.index = '0;
    ans.status = STAT_OK;
    best = TABLE_DEPTH * TABLE_DEPTH * 3;
    if (first + count > int'(pool_count)) begin
      ans.status = STAT_INVALID;
    end else if (count == 0) begin
      ans.status = STAT_NOT_FOUND;
    end else begin
      for (int i = first; i < first + count; i++) begin
        cand_dist = int'(rgb_distance(color, pool_colors[i]));
        if (cand_dist < best) begin
          best = cand_dist;
          ans.index = i[IDX_W-1:0];
        end
      end
    end
    return ans;
  endfunction

  // Exact match first, then an append if there is room. The capacity register cannot
  // exceed 255, so it never needs clamping to the table depth here.
  function automatic pool_answer_t register_color(input logic [COLOR_W-1:0] color);
    pool_answer_t ans;
    bit found;
    ans.index = '0;
    ans.status = STAT_OK;
    found = 1'b0;
    if (pool_capacity == 0) begin
      ans.status = STAT_INVALID;
    end else begin
      for (int i = 0; i < int'(pool_count); i++) begin
        if (!found && pool_colors[i] == color) begin
          found = 1'b1;
          ans.index = i[IDX_W-1:0];
        end
      end
      if (!found) begin
        if (pool_count >= pool_capacity) begin
          ans.status = STAT_FULL;
        end else begin
          pool_colors[pool_count] = color;
          ans.index = pool_count;
          pool_count = pool_count + 1'b1;
        end
      end
    end
    return ans;
  endfunction

  function automatic pool_answer_t serve_request(input color_req_t r);
    pool_answer_t ans;
    case (r.kind)
      REQ_REGISTER: ans = register_color(r.color);
      REQ_RANGE:    ans = nearest_color(r.color, int'(r.first), int'(r.count));
      REQ_ALL:      ans = nearest_color(r.color, 0, int'(pool_count));
      default: begin
        ans.index = '0;
        ans.status = STAT_INVALID;
      end
    endcase
    return ans;
  endfunction

  // Driver. It sends bursts of random length separated by random gaps. A new request is
  // only presented when the line is empty or its request is being taken at this edge,
  // so a pending request holds valid and payload steady until it transfers.
  always @(posedge clk) begin : request_driver
    int burst_left;
    int gap_left;
    color_req_t next_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_answers.push_back(serve_request(
          '{in_req_type, in_color, in_range_first, in_range_count}));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (color_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          next_req = color_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_req.kind;
          in_color <= next_req.color;
          in_range_first <= next_req.first;
          in_range_count <= next_req.count;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // Monitor. The ready pattern switches every so often between always ready, a coin
  // flip each cycle, and mostly stalled, so finished results wait at the output under each pattern.
  always @(posedge clk) begin : result_monitor
    int ready_mode;
    int ready_span;
    pool_answer_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_mode = 0;
      ready_span = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_answers.size() == 0) begin
          $error("result transfer with no request waiting: index %0d status %0d",
                 out_index, out_status);
          error_count++;
        end else begin
          want = predicted_answers.pop_front();
          if (out_index !== want.index) begin
            $error("index mismatch: expected %0d, actual %0d", want.index, out_index);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
        end
      end
      if (ready_span == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_span = $urandom_range(20, 300);
      end
      ready_span = ready_span - 1;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic queue_request(input req_t kind, input logic [COLOR_W-1:0] color,
                               input logic [IDX_W-1:0] first,
                               input logic [IDX_W-1:0] count);
    color_requests.push_back('{kind, color, first, count});
  endtask

  // Holds off until nothing is queued, on the line or in flight, then lets the unit
  // settle. This is also how the sender is paused for pressure. The check runs at the
  // falling edge, once the driver's updates have landed.
  task automatic wait_idle();
    while (color_requests.size() != 0 || in_valid || predicted_answers.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_capacity = value;
  endtask

  // One random request, shaped from the current pool so most searches use a valid
  // range and many registrations hit a stored color. The queue is kept short so the
  // pool seen here is never more than a few requests behind. Since entries are only
  // ever appended, a range valid now stays valid when the request transfers.
  task automatic queue_random_request();
    int pick;
    int stored;
    int span;
    color_req_t r;
    while (color_requests.size() >= 2) @(posedge clk);
    stored = int'(pool_count);
    pick = $urandom_range(0, 99);
    r.color = COLOR_W'($urandom());
    r.first = IDX_W'($urandom());
    r.count = IDX_W'($urandom());
    if (pick < 35) begin
      r.kind = REQ_REGISTER;
      if (stored != 0 && pick < 18) r.color = pool_colors[$urandom_range(0, stored - 1)];
    end else if (pick < 70) begin
      r.kind = REQ_RANGE;
      r.first = (stored == 0) ? '0 : IDX_W'($urandom_range(0, stored - 1));
      span = stored - int'(r.first);
      if ($urandom_range(0, 9) == 0) r.count = IDX_W'(span);
      else r.count = IDX_W'($urandom_range(0, (span < 12) ? span : 12));
      if (stored != 0 && pick < 45) r.color = pool_colors[$urandom_range(0, stored - 1)];
    end else if (pick < 90) begin
      r.kind = REQ_ALL;
    end else if (pick < 93) begin
      r.kind = REQ_UNUSED;
    end else begin
      // Unshaped range: almost always past the entry count.
      r.kind = REQ_RANGE;
    end
    color_requests.push_back(r);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table with the reset capacity: searches find nothing, nonempty ranges are rejected.
    queue_request(REQ_ALL, 15'h1234, 8'd0, 8'd0);
    queue_request(REQ_RANGE, 15'h1234, 8'd0, 8'd0);
    queue_request(REQ_RANGE, 15'h1234, 8'd0, 8'd1);
    queue_request(REQ_RANGE, 15'h7FFF, 8'd255, 8'd255);
    queue_request(REQ_UNUSED, 15'h7FFF, 8'd255, 8'd255);

    // Zero capacity rejects a registration and leaves the table empty.
    write_capacity(8'd0);
    queue_request(REQ_REGISTER, 15'h1234, 8'd0, 8'd0);
    queue_request(REQ_ALL, 15'h1234, 8'd0, 8'd0);

    // Small capacity: fill it, hit duplicates, then overflow it. The corner colors are
    // placed so that the query 03FF lies equally far from several entries.
    write_capacity(8'd4);
    queue_request(REQ_REGISTER, 15'h0000, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h7FFF, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h0000, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h001F, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h03E0, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h7C00, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h7FFF, 8'd0, 8'd0);
    queue_request(REQ_ALL, 15'h03FF, 8'd0, 8'd0);
    queue_request(REQ_RANGE, 15'h03FF, 8'd2, 8'd2);
    queue_request(REQ_RANGE, 15'h03FF, 8'd3, 8'd1);
    queue_request(REQ_RANGE, 15'h03FF, 8'd4, 8'd0);
    queue_request(REQ_RANGE, 15'h03FF, 8'd4, 8'd1);
    queue_request(REQ_RANGE, 15'h7C00, 8'd0, 8'd4);
    queue_request(REQ_ALL, 15'h7FFF, 8'd0, 8'd0);

    // Capacity dropped below the entry count: old colors still match, new ones are full.
    write_capacity(8'd1);
    queue_request(REQ_REGISTER, 15'h5555, 8'd0, 8'd0);
    queue_request(REQ_REGISTER, 15'h03E0, 8'd0, 8'd0);

    // Random traffic at full capacity, with the sender paused now and then until every
    // result is back.
    write_capacity(CAP_MAX);
    for (int n = 0; n < 350; n++) begin
      queue_random_request();
      if (n % 120 == 119) wait_idle();
    end

    // Random traffic under a random capacity, likely below the entry count by now.
    write_capacity(8'($urandom_range(1, 254)));
    for (int n = 0; n < 150; n++) queue_random_request();

    // Fill the pool up to the 255-entry capacity with fresh colors, then keep going while full.
    write_capacity(CAP_MAX);
    while (pool_count < CAP_MAX) begin
      while (color_requests.size() >= 2) @(posedge clk);
      queue_request(REQ_REGISTER, COLOR_W'($urandom()), IDX_W'($urandom()),
                    IDX_W'($urandom()));
    end
    for (int n = 0; n < 150; n++) queue_random_request();

    // Let the last results drain, then give the unit time to produce anything stray.
    wait_idle();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run, which is a few million nanoseconds.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
